// ===== design/pche_pkg.sv =====
`timescale 1ns / 1ps
package pche_pkg;

   // Unit parameter t and its powers carry this many fraction bits.
   localparam int Q_BITS = 30;
   localparam logic [30:0] Q_ONE = 31'h4000_0000;

   localparam logic [1:0] STATUS_OK         = 2'd0;
   localparam logic [1:0] STATUS_ZERO_WIDTH = 2'd1;
   localparam logic [1:0] STATUS_SATURATED  = 2'd2;

   localparam logic REQ_WRITE_KNOT = 1'b0;
   localparam logic REQ_EVALUATE   = 1'b1;

   typedef struct packed {
      logic [31:0] pos;
      logic [31:0] value;
      logic [31:0] slope;
   } knot_entry_type;

   typedef enum logic [3:0] {
      OP_T2, OP_S2, OP_TS, OP_T3, OP_S3, OP_TS2, OP_T2S, OP_HTS2,
      OP_HT2S, OP_VF0, OP_VF1, OP_VD0, OP_VD1, OP_SQ, OP_SD0, OP_SD1
   } mul_op_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_SCAN, ST_SCAN_WAIT, ST_INDEX, ST_RD_LEFT, ST_RD_RIGHT,
      ST_CAP_RIGHT, ST_CHECK, ST_DIV_T, ST_SET_T, ST_MUL, ST_LOAD_Q,
      ST_DIV_Q, ST_SUM, ST_SAT, ST_OUT
   } ctrl_state_type;

   typedef struct packed {
      logic       write_knot;
      logic       accept_eval;
      logic       scan_rd;
      logic       set_id;
      logic       rd_left;
      logic       rd_right;
      logic       cap_left;
      logic       cap_right;
      logic       check;
      logic       div_step;
      logic       set_t;
      logic       mul_go;
      mul_op_type mul_op;
      logic       load_q;
      logic       sum;
      logic       sat;
      logic       load_out;
   } dp_cmd_type;

   typedef struct packed {
      logic scan_last;
      logic zero_width;
      logic out_free;
   } dp_status_type;

endpackage

// ===== design/pche_ctrl.sv =====
`timescale 1ns / 1ps
module pche_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_type,
   output logic                   req_stall,
   input  pche_pkg::dp_status_type status,
   output pche_pkg::dp_cmd_type   cmd
);
   import pche_pkg::*;

   ctrl_state_type state_ff, state_in;
   logic [5:0]     step_ff;
   logic           step_last;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= (state_ff != state_in) ? 6'd0 : step_ff + 6'd1;
      end
   end

   assign step_last = (step_ff == 6'd63);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:      if (req_valid && req_type == REQ_EVALUATE) state_in = ST_SCAN;
         ST_SCAN:      if (status.scan_last) state_in = ST_SCAN_WAIT;
         ST_SCAN_WAIT: state_in = ST_INDEX;
         ST_INDEX:     state_in = ST_RD_LEFT;
         ST_RD_LEFT:   state_in = ST_RD_RIGHT;
         ST_RD_RIGHT:  state_in = ST_CAP_RIGHT;
         ST_CAP_RIGHT: state_in = ST_CHECK;
         ST_CHECK:     state_in = status.zero_width ? ST_OUT : ST_DIV_T;
         ST_DIV_T:     if (step_last) state_in = ST_SET_T;
         ST_SET_T:     state_in = ST_MUL;
         ST_MUL:       if (step_ff == 6'd31) state_in = ST_LOAD_Q;
         ST_LOAD_Q:    state_in = ST_DIV_Q;
         ST_DIV_Q:     if (step_last) state_in = ST_SUM;
         ST_SUM:       state_in = ST_SAT;
         ST_SAT:       state_in = ST_OUT;
         ST_OUT:       if (status.out_free) state_in = ST_IDLE;
         default:      state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      cmd.mul_op = mul_op_type'(step_ff[4:1]);
      req_stall = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall       = 1'b0;
            cmd.write_knot  = req_valid && (req_type == REQ_WRITE_KNOT);
            cmd.accept_eval = req_valid && (req_type == REQ_EVALUATE);
         end
         ST_SCAN:      cmd.scan_rd = 1'b1;
         ST_SCAN_WAIT: cmd.set_id = 1'b0;
         ST_INDEX:     cmd.set_id = 1'b1;
         ST_RD_LEFT:   cmd.rd_left = 1'b1;
         ST_RD_RIGHT: begin
            cmd.rd_right = 1'b1;
            cmd.cap_left = 1'b1;
         end
         ST_CAP_RIGHT: cmd.cap_right = 1'b1;
         ST_CHECK:     cmd.check = 1'b1;
         ST_DIV_T:     cmd.div_step = 1'b1;
         ST_SET_T:     cmd.set_t = 1'b1;
         ST_MUL:       cmd.mul_go = ~step_ff[0];
         ST_LOAD_Q:    cmd.load_q = 1'b1;
         ST_DIV_Q:     cmd.div_step = 1'b1;
         ST_SUM:       cmd.sum = 1'b1;
         ST_SAT:       cmd.sat = 1'b1;
         ST_OUT:       cmd.load_out = status.out_free;
         default:      cmd = '0;
      endcase
   end

endmodule

// ===== design/pche_dp.sv =====
`timescale 1ns / 1ps
module pche_dp #(
   parameter int MAX_KNOTS = 64,
   parameter int FRAC_BITS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [5:0]             req_entry_index,
   input  logic signed [31:0]     req_knot_pos,
   input  logic signed [31:0]     req_knot_value,
   input  logic signed [31:0]     req_knot_slope,
   input  logic signed [31:0]     req_query_x,
   input  logic                   csr_we,
   input  logic [6:0]             csr_wdata,
   input  pche_pkg::dp_cmd_type   cmd,
   output pche_pkg::dp_status_type status,
   input  logic                   rsp_stall,
   output logic                   rsp_valid,
   output logic signed [31:0]     rsp_interp_value,
   output logic signed [31:0]     rsp_interp_slope,
   output logic [1:0]             rsp_status
);
   import pche_pkg::*;

   localparam int AW = (MAX_KNOTS > 2) ? $clog2(MAX_KNOTS) : 1;
   localparam int NW = ($clog2(MAX_KNOTS + 1) > 7) ? $clog2(MAX_KNOTS + 1) : 7;
   localparam int SW = Q_BITS - FRAC_BITS;
   localparam logic signed [69:0] SAT_HI = 70'sd2147483647;
   localparam logic signed [69:0] SAT_LO = -70'sd2147483648;

   function automatic logic signed [33:0] ext_u31(input logic [30:0] v);
      return $signed({3'b000, v});
   endfunction

   function automatic logic signed [33:0] ext_s32(input logic [31:0] v);
      return $signed({{2{v[31]}}, v});
   endfunction

   // table and configuration
   knot_entry_type knot_mem_ff [MAX_KNOTS];
   knot_entry_type knot_rd_ff;
   logic [6:0]     knot_count_ff;
   logic [NW-1:0]  n_w;
   logic [AW+5:0]  wr_ext;
   logic [AW-1:0]  rd_addr;
   logic           mem_we, mem_re;

   // search
   logic [NW-1:0]  ptr_ff, cnt_ff, id_ff, id_in, id_one;
   logic           scan_vld_ff;
   logic signed [31:0] x_ff, x0_ff, f0_ff, d0_ff, x1_ff, f1_ff, d1_ff;
   logic signed [32:0] fdiff_ff;
   logic signed [31:0] x_c;

   // divider
   logic [31:0]    h_ff, rem_ff, a_w, rem_in;
   logic [63:0]    quo_ff;
   logic           quo_neg_ff;
   logic [32:0]    div_tmp, div_diff;
   logic           div_ge;

   // multiplier and terms
   logic [30:0]    t_ff, s_ff, t2_ff, s2_ff, ts2_ff, t2s_ff;
   logic [31:0]    hts2_ff, ht2s_ff;
   logic signed [33:0] phit_ff, phis_ff, dpt_ff, dps_ff, ts6_ff, pq34;
   logic signed [33:0] op_a, op_b;
   logic signed [67:0] product_ff, pq, acc_v_ff, acc_d_ff, acc_s_ff, num_ff, num_abs;
   mul_op_type     op_q_ff;
   logic           wb_ff;

   // results
   logic signed [64:0] q_w;
   logic signed [69:0] val_sum_ff, slp_sum_ff;
   logic signed [31:0] res_val_ff, res_slp_ff;
   logic [1:0]         res_st_ff;
   logic               sat_v, sat_s;
   logic               rsp_valid_ff;
   logic signed [31:0] rsp_val_ff, rsp_slp_ff;
   logic [1:0]         rsp_st_ff;

   always_comb begin
      if (knot_count_ff < 7'd2) n_w = NW'(2);
      else if (int'(knot_count_ff) > MAX_KNOTS) n_w = NW'(MAX_KNOTS);
      else n_w = NW'(knot_count_ff);
   end

   assign wr_ext = {{AW{1'b0}}, req_entry_index};
   assign mem_we = cmd.write_knot && (int'(req_entry_index) < MAX_KNOTS);
   assign mem_re = cmd.scan_rd || cmd.rd_left || cmd.rd_right;
   assign id_one = id_ff + NW'(1);

   always_comb begin
      rd_addr = ptr_ff[AW-1:0];
      if (cmd.rd_left) rd_addr = id_ff[AW-1:0];
      else if (cmd.rd_right) rd_addr = id_one[AW-1:0];
   end

   always_ff @(posedge clock) begin
      if (mem_we) knot_mem_ff[wr_ext[AW-1:0]] <= '{req_knot_pos, req_knot_value,
                                                   req_knot_slope};
      if (mem_re) knot_rd_ff <= knot_mem_ff[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) knot_count_ff <= 7'd2;
      else if (csr_we) knot_count_ff <= csr_wdata;
   end

   // lower-bound count over the used entries, one per cycle
   always_comb begin
      id_in = (cnt_ff == '0) ? '0 : cnt_ff - NW'(1);
      if (id_in > n_w - NW'(2)) id_in = n_w - NW'(2);
   end

   always_ff @(posedge clock) begin
      if (reset) scan_vld_ff <= 1'b0;
      else scan_vld_ff <= cmd.scan_rd;
   end

   always_ff @(posedge clock) begin
      if (cmd.accept_eval) begin
         x_ff   <= req_query_x;
         ptr_ff <= '0;
         cnt_ff <= '0;
      end else begin
         if (cmd.scan_rd) ptr_ff <= ptr_ff + NW'(1);
         if (scan_vld_ff && ($signed(knot_rd_ff.pos) < x_ff)) cnt_ff <= cnt_ff + NW'(1);
      end
      if (cmd.set_id) id_ff <= id_in;
      if (cmd.cap_left) begin
         x0_ff <= knot_rd_ff.pos;
         f0_ff <= knot_rd_ff.value;
         d0_ff <= knot_rd_ff.slope;
      end
      if (cmd.cap_right) begin
         x1_ff    <= knot_rd_ff.pos;
         f1_ff    <= knot_rd_ff.value;
         d1_ff    <= knot_rd_ff.slope;
         fdiff_ff <= 33'($signed(knot_rd_ff.value)) - 33'(f0_ff);
      end
   end

   assign status.scan_last  = (ptr_ff == n_w - NW'(1));
   assign status.zero_width = (x1_ff <= x0_ff);
   assign status.out_free   = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      x_c = x_ff;
      if (x_ff < x0_ff) x_c = x0_ff;
      else if (x_ff > x1_ff) x_c = x1_ff;
   end
   assign a_w = x_c - x0_ff;

   // restoring divider, one quotient bit per cycle, divisor h
   assign div_tmp  = {rem_ff, quo_ff[63]};
   assign div_ge   = (div_tmp >= {1'b0, h_ff});
   assign div_diff = div_tmp - {1'b0, h_ff};
   assign rem_in   = div_ge ? div_diff[31:0] : div_tmp[31:0];
   assign num_abs  = num_ff[67] ? -num_ff : num_ff;

   always_ff @(posedge clock) begin
      if (cmd.check) begin
         h_ff   <= x1_ff - x0_ff;
         rem_ff <= '0;
         quo_ff <= {2'b00, a_w, 30'd0};
      end else if (cmd.load_q) begin
         rem_ff     <= '0;
         quo_ff     <= num_abs[63:0];
         quo_neg_ff <= num_ff[67];
      end else if (cmd.div_step) begin
         rem_ff <= rem_in;
         quo_ff <= {quo_ff[62:0], div_ge};
      end
      if (cmd.set_t) begin
         t_ff <= quo_ff[30:0];
         s_ff <= Q_ONE - quo_ff[30:0];
      end
   end

   // one shared multiplier; write back in the cycle after issue
   always_comb begin
      op_a = ext_u31(t_ff);
      op_b = ext_u31(t_ff);
      case (cmd.mul_op)
         OP_T2:   begin op_a = ext_u31(t_ff);   op_b = ext_u31(t_ff);   end
         OP_S2:   begin op_a = ext_u31(s_ff);   op_b = ext_u31(s_ff);   end
         OP_TS:   begin op_a = ext_u31(t_ff);   op_b = ext_u31(s_ff);   end
         OP_T3:   begin op_a = ext_u31(t2_ff);  op_b = ext_u31(t_ff);   end
         OP_S3:   begin op_a = ext_u31(s2_ff);  op_b = ext_u31(s_ff);   end
         OP_TS2:  begin op_a = ext_u31(t_ff);   op_b = ext_u31(s2_ff);  end
         OP_T2S:  begin op_a = ext_u31(t2_ff);  op_b = ext_u31(s_ff);   end
         OP_HTS2: begin op_a = $signed({2'b00, h_ff}); op_b = ext_u31(ts2_ff); end
         OP_HT2S: begin op_a = $signed({2'b00, h_ff}); op_b = ext_u31(t2s_ff); end
         OP_VF0:  begin op_a = ext_s32(f0_ff);  op_b = phis_ff;         end
         OP_VF1:  begin op_a = ext_s32(f1_ff);  op_b = phit_ff;         end
         OP_VD0:  begin op_a = ext_s32(d0_ff);  op_b = $signed({2'b00, hts2_ff}); end
         OP_VD1:  begin op_a = ext_s32(d1_ff);  op_b = $signed({2'b00, ht2s_ff}); end
         OP_SQ:   begin op_a = 34'(fdiff_ff);   op_b = ts6_ff;          end
         OP_SD0:  begin op_a = ext_s32(d0_ff);  op_b = dps_ff;          end
         OP_SD1:  begin op_a = ext_s32(d1_ff);  op_b = dpt_ff;          end
         default: begin op_a = '0;              op_b = '0;              end
      endcase
   end

   assign pq   = product_ff >>> Q_BITS;
   assign pq34 = pq[33:0];

   always_ff @(posedge clock) begin
      if (reset) wb_ff <= 1'b0;
      else wb_ff <= cmd.mul_go;
   end

   always_ff @(posedge clock) begin
      if (cmd.mul_go) begin
         product_ff <= op_a * op_b;
         op_q_ff    <= cmd.mul_op;
      end
      if (wb_ff) begin
         case (op_q_ff)
            OP_T2: begin
               t2_ff  <= pq[30:0];
               dpt_ff <= (pq34 <<< 1) + pq34 - (ext_u31(t_ff) <<< 1);
            end
            OP_S2: begin
               s2_ff  <= pq[30:0];
               dps_ff <= (pq34 <<< 1) + pq34 - (ext_u31(s_ff) <<< 1);
            end
            OP_TS:   ts6_ff  <= (pq34 <<< 2) + (pq34 <<< 1);
            OP_T3:   phit_ff <= (ext_u31(t2_ff) <<< 1) + ext_u31(t2_ff) - (pq34 <<< 1);
            OP_S3:   phis_ff <= (ext_u31(s2_ff) <<< 1) + ext_u31(s2_ff) - (pq34 <<< 1);
            OP_TS2:  ts2_ff  <= pq[30:0];
            OP_T2S:  t2s_ff  <= pq[30:0];
            OP_HTS2: hts2_ff <= pq[31:0];
            OP_HT2S: ht2s_ff <= pq[31:0];
            OP_VF0:  acc_v_ff <= product_ff;
            OP_VF1:  acc_v_ff <= acc_v_ff + product_ff;
            OP_VD0:  acc_d_ff <= product_ff;
            OP_VD1:  acc_d_ff <= acc_d_ff - product_ff;
            OP_SQ:   num_ff   <= product_ff;
            OP_SD0:  acc_s_ff <= product_ff;
            OP_SD1:  acc_s_ff <= acc_s_ff + product_ff;
            default: acc_s_ff <= acc_s_ff;
         endcase
      end
   end

   // truncating signed quotient of the slope term
   assign q_w = quo_neg_ff ? -$signed({1'b0, quo_ff}) : $signed({1'b0, quo_ff});

   assign sat_v = (val_sum_ff > SAT_HI) || (val_sum_ff < SAT_LO);
   assign sat_s = (slp_sum_ff > SAT_HI) || (slp_sum_ff < SAT_LO);

   always_ff @(posedge clock) begin
      if (cmd.sum) begin
         val_sum_ff <= 70'(acc_v_ff >>> Q_BITS) + 70'(acc_d_ff >>> FRAC_BITS);
         slp_sum_ff <= 70'(q_w >>> SW) + 70'(acc_s_ff >>> Q_BITS);
      end
      if (cmd.check && status.zero_width) begin
         res_val_ff <= f0_ff;
         res_slp_ff <= '0;
         res_st_ff  <= STATUS_ZERO_WIDTH;
      end else if (cmd.sat) begin
         res_val_ff <= val_sum_ff > SAT_HI ? 32'sh7FFF_FFFF :
                       val_sum_ff < SAT_LO ? 32'sh8000_0000 : val_sum_ff[31:0];
         res_slp_ff <= slp_sum_ff > SAT_HI ? 32'sh7FFF_FFFF :
                       slp_sum_ff < SAT_LO ? 32'sh8000_0000 : slp_sum_ff[31:0];
         res_st_ff  <= (sat_v || sat_s) ? STATUS_SATURATED : STATUS_OK;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (cmd.load_out) rsp_valid_ff <= 1'b1;
      else if (!rsp_stall) rsp_valid_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         rsp_val_ff <= res_val_ff;
         rsp_slp_ff <= res_slp_ff;
         rsp_st_ff  <= res_st_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_interp_value = rsp_val_ff;
   assign rsp_interp_slope = rsp_slp_ff;
   assign rsp_status       = rsp_st_ff;

endmodule

// ===== design/piecewise_cubic_hermite_eval_core.sv =====
`timescale 1ns / 1ps
// A knot write takes effect at its accept edge and gives no response. An evaluate
// (n = knots in use) runs a table scan of the n knots on the one read port, two
// divider runs, 16 products through one shared multiplier, and sequencing states.
// A zero-width segment skips the arithmetic. One transaction is in flight at a time;
// the next is taken at IDLE, and a stalled response holds it off.
// Reset (synchronous, active high) clears the FSM, output valid and knot_count=2.
module piecewise_cubic_hermite_eval_core #(
   parameter int MAX_KNOTS = 64,
   parameter int FRAC_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   // request channel
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_type,
   input  logic [5:0]         req_entry_index,
   input  logic signed [31:0] req_knot_pos,
   input  logic signed [31:0] req_knot_value,
   input  logic signed [31:0] req_knot_slope,
   input  logic signed [31:0] req_query_x,
   // knot_count register
   input  logic               csr_we,
   input  logic [6:0]         csr_wdata,
   // response channel
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_interp_value,
   output logic signed [31:0] rsp_interp_slope,
   output logic [1:0]         rsp_status
);
   import pche_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   // Sequence the search, divide and multiply steps of one transaction.
   pche_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_type  (req_type),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // Hold the knot table, the shared divider and multiplier, and the output register.
   pche_dp #(
      .MAX_KNOTS (MAX_KNOTS),
      .FRAC_BITS (FRAC_BITS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .req_entry_index  (req_entry_index),
      .req_knot_pos     (req_knot_pos),
      .req_knot_value   (req_knot_value),
      .req_knot_slope   (req_knot_slope),
      .req_query_x      (req_query_x),
      .csr_we           (csr_we),
      .csr_wdata        (csr_wdata),
      .cmd              (cmd),
      .status           (status),
      .rsp_stall        (rsp_stall),
      .rsp_valid        (rsp_valid),
      .rsp_interp_value (rsp_interp_value),
      .rsp_interp_slope (rsp_interp_slope),
      .rsp_status       (rsp_status)
   );

endmodule

// ===== design/pche_checker.sv =====
`timescale 1ns / 1ps
module pche_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input logic               req_type,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic signed [31:0] rsp_interp_value,
   input logic signed [31:0] rsp_interp_slope,
   input logic [1:0]         rsp_status
);
   import pche_pkg::*;

   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_interp_value)
         && $stable(rsp_interp_slope) && $stable(rsp_status))
      else $error("stalled response changed");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status <= STATUS_SATURATED)
      else $error("undefined status code");

   a_zero_width: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_ZERO_WIDTH |-> rsp_interp_slope == 32'sd0)
      else $error("zero-width segment with nonzero slope");

   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_type == REQ_EVALUATE |=> req_stall)
      else $error("request taken while an evaluate is in progress");

endmodule

bind piecewise_cubic_hermite_eval_core pche_checker u_pche_checker (.*);
